/* src/spd_pkg.sv */
// Package for the stereo position delay/gain block.
// Holds ring sizes, gain constants, position decode and lane control types.
// No dependencies.
package spd_pkg;

    localparam int RING_DEPTH    = 64;
    localparam int DELAY_SAMPLES = 36;
    localparam int IDX_W         = $clog2(RING_DEPTH);

    localparam int SAMPLE_W = 16;
    localparam int FIFTHS_W = 3;
    localparam int POS_W    = 3;
    localparam int MAG_PROD_W = 18;

    // x/5 == (x * RECIP_FIFTH) >> RECIP_SHIFT for all x < 2**18
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP_FIFTH = RECIP_W'((2**RECIP_SHIFT + 4) / 5);

    localparam logic [0:0] REG_POSITION = 1'b0;
    localparam logic [0:0] REG_ENABLE   = 1'b1;

    typedef logic [IDX_W-1:0] ring_idx_t;

    typedef struct packed {
        logic                left_delayed;
        logic                right_delayed;
        logic [FIFTHS_W-1:0] left_fifths;
        logic [FIFTHS_W-1:0] right_fifths;
    } pos_cfg_t;

    typedef struct packed {
        logic                adv;
        logic                fire;
        logic                bypass;
        logic                delayed;
        logic [FIFTHS_W-1:0] fifths;
        ring_idx_t           idx;
    } lane_ctrl_t;

    function automatic pos_cfg_t pos_decode(input logic [POS_W-1:0] pos);
        pos_cfg_t cfg;
        cfg = '0;
        unique case (pos)
            3'd0, 3'd1:
            begin
                cfg.left_fifths  = 3'd5;
                cfg.right_fifths = 3'd0;
            end
            3'd2:
            begin
                cfg.left_fifths   = 3'd4;
                cfg.right_fifths  = 3'd3;
                cfg.right_delayed = 1'b1;
            end
            3'd3:
            begin
                cfg.left_fifths  = 3'd5;
                cfg.right_fifths = 3'd5;
            end
            3'd4:
            begin
                cfg.left_fifths  = 3'd3;
                cfg.right_fifths = 3'd4;
                cfg.left_delayed = 1'b1;
            end
            default:
            begin
                cfg.left_fifths  = 3'd0;
                cfg.right_fifths = 3'd5;
            end
        endcase
        return cfg;
    endfunction

    function automatic ring_idx_t ring_add(input ring_idx_t base, input int unsigned offs);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + (IDX_W+1)'(offs);
        if (sum >= (IDX_W+1)'(RING_DEPTH))
        begin
            sum = sum - (IDX_W+1)'(RING_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

/* src/spd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module spd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/spd_lane.sv */
// One channel lane: ring RAM with valid bits, delay tap and fifths gain pipeline.
// Depends on spd_pkg and spd_ram.
module spd_lane
    import spd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [SAMPLE_W-1:0] result
);

    logic [RING_DEPTH-1:0] valid_reg;
    logic [RING_DEPTH-1:0] valid_next;
    ring_idx_t             waddr;
    logic                  wr_en;
    logic [SAMPLE_W-1:0]   rdata;

    // stage 1
    logic                       bypass1_reg;
    logic                       fwd1_reg;
    logic                       hit1_reg;
    logic [FIFTHS_W-1:0]        fifths1_reg;
    logic signed [SAMPLE_W-1:0] samp1_reg;

    // stage 2
    logic                       bypass2_reg;
    logic                       neg2_reg;
    logic [MAG_PROD_W-1:0]      prod2_reg;
    logic signed [SAMPLE_W-1:0] samp2_reg;

    logic signed [SAMPLE_W-1:0]      src;
    logic [SAMPLE_W-1:0]             mag;
    logic [SAMPLE_W+FIFTHS_W-1:0]    prod_full;
    logic [MAG_PROD_W+RECIP_W-1:0]   recip_prod;
    logic [SAMPLE_W-1:0]             quot;
    logic [SAMPLE_W:0]               signed_quot;

    assign waddr = ring_add(ctrl.idx, ctrl.delayed ? DELAY_SAMPLES : 0);
    assign wr_en = ctrl.fire && !ctrl.bypass;

    spd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (sample),
        .re    (ctrl.adv),
        .raddr (ctrl.idx),
        .rdata (rdata)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            bypass1_reg <= ctrl.bypass;
            fwd1_reg    <= !ctrl.delayed;
            hit1_reg    <= valid_reg[ctrl.idx];
            fifths1_reg <= ctrl.fifths;
            samp1_reg   <= sample;
        end
    end

    // undelayed tap reads the sample written in the same transaction
    always_comb
    begin
        if (fwd1_reg)
        begin
            src = samp1_reg;
        end
        else if (hit1_reg)
        begin
            src = signed'(rdata);
        end
        else
        begin
            src = '0;
        end
        mag       = src[SAMPLE_W-1] ? SAMPLE_W'(-src) : SAMPLE_W'(src);
        prod_full = mag * fifths1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            bypass2_reg <= bypass1_reg;
            neg2_reg    <= src[SAMPLE_W-1];
            prod2_reg   <= prod_full[MAG_PROD_W-1:0];
            samp2_reg   <= samp1_reg;
        end
    end

    always_comb
    begin
        recip_prod  = prod2_reg * RECIP_FIFTH;
        quot        = recip_prod[RECIP_SHIFT +: SAMPLE_W];
        signed_quot = neg2_reg ? -{1'b0, quot} : {1'b0, quot};
        result      = bypass2_reg ? samp2_reg : signed'(signed_quot[SAMPLE_W-1:0]);
    end

endmodule

/* src/stereo_position_delay_gain.sv */
// Top level of the stereo position delay/gain block: config registers, shared
// ring index, two channel lanes and the merging output register.
// Depends on spd_pkg and spd_lane.
//
//  channel   | signals                             | payload
//  ----------+-------------------------------------+--------------------------------
//  s_axis    | s_axis_tvalid/tready/tdata[31:0]    | left_sample, right_sample
//  m_axis    | m_axis_tvalid/tready/tdata[31:0]    | left_out, right_out
//  cfg       | cfg_we, cfg_index, cfg_data[2:0]    | 0: spatial_position, 1: enable
//
// One stereo pair per cycle sustained while m_axis accepts; each pair passes the ring read
// register, the sample-times-fifths stage and the reciprocal multiply into the output register.
// Ring contents reset to zero through per-entry valid bits; no clearing pass.
// A stall on m_axis freezes the whole pipeline and drops s_axis_tready.
module stereo_position_delay_gain
    import spd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [15:0] left_out, [31:16] right_out
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [POS_W-1:0]  cfg_data
);

    logic [POS_W-1:0] position_reg;
    logic             enable_reg;
    ring_idx_t        idx_reg;
    ring_idx_t        idx_next;
    ring_idx_t        idx_inc;

    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;
    logic [2*SAMPLE_W-1:0] out_data_reg;

    logic       adv;
    logic       fire;
    pos_cfg_t   pos_cfg;
    lane_ctrl_t left_ctrl;
    lane_ctrl_t right_ctrl;
    logic signed [SAMPLE_W-1:0] left_result;
    logic signed [SAMPLE_W-1:0] right_result;

    assign adv  = !out_valid_reg || m_axis_tready;
    assign fire = s_axis_tvalid && adv;
    assign s_axis_tready = adv;

    assign pos_cfg = pos_decode(position_reg);
    assign idx_inc = ring_add(idx_reg, 1);
    assign idx_next = (fire && enable_reg) ? idx_inc : idx_reg;

    always_comb
    begin
        left_ctrl.adv      = adv;
        left_ctrl.fire     = fire;
        left_ctrl.bypass   = !enable_reg;
        left_ctrl.delayed  = pos_cfg.left_delayed;
        left_ctrl.fifths   = pos_cfg.left_fifths;
        left_ctrl.idx      = idx_reg;
        right_ctrl         = left_ctrl;
        right_ctrl.delayed = pos_cfg.right_delayed;
        right_ctrl.fifths  = pos_cfg.right_fifths;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= POS_W'(3);
            enable_reg    <= 1'b1;
            idx_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POSITION: position_reg <= cfg_data;
                    REG_ENABLE:   enable_reg   <= cfg_data[0];
                    default:      ;
                endcase
            end
            idx_reg <= idx_next;
            if (adv)
            begin
                v1_reg        <= s_axis_tvalid;
                v2_reg        <= v1_reg;
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {right_result, left_result};
        end
    end

    spd_lane u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (left_ctrl),
        .sample (s_axis_tdata[SAMPLE_W-1:0]),
        .result (left_result)
    );

    spd_lane u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (right_ctrl),
        .sample (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .result (right_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_bypass_holds_index: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !enable_reg) |=> $stable(idx_reg))
        else $error("ring index moved on a bypass transaction");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && enable_reg) |=> (idx_reg == $past(idx_inc)))
        else $error("ring index did not advance by one");

    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    a_pipe_feeds_output: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v2_reg) |=> out_valid_reg)
        else $error("pipeline transaction lost before output");

endmodule

/* test/stereo_position_delay_gain_tb.sv */
// Testbench for stereo_position_delay_gain: directed table, then randomized phases with
// idling, long output stalls and register changes between phases, checked against a predictor.
// Depends on spd_pkg and the stereo_position_delay_gain RTL.
module stereo_position_delay_gain_tb;
    import spd_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 16;
    localparam int PHASE_ITEMS   = 50;
    localparam int DIR_ROWS      = 17;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } stereo_t;

    typedef struct packed {
        int pos;
        int en;
        int l;
        int r;
        int chk;
        int el;
        int er;
    } dir_row_t;

    // chk = 1: expected pair typed in; otherwise taken from the predictor
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{3, 1,      0,      0, 1,      0,      0},
        '{3, 1,  32767, -32768, 1,  32767, -32768},
        '{3, 1, -32768,  32767, 1, -32768,  32767},
        '{3, 1,     -1,      1, 1,     -1,      1},
        '{0, 1,  12345, -12345, 1,  12345,      0},
        '{1, 1, -32768,  32767, 1, -32768,      0},
        '{7, 1, -32768,  32767, 1,      0,  32767},
        '{5, 1,   1234,  -4321, 1,      0,  -4321},
        '{6, 1,      5,     -5, 1,      0,     -5},
        '{2, 1, -32768,  32767, 0,      0,      0},
        '{2, 1,  32767,     -1, 0,      0,      0},
        '{4, 1,  32767, -32768, 0,      0,      0},
        '{4, 1,     -5,      4, 0,      0,      0},
        '{4, 0, -32768,  32767, 1, -32768,  32767},
        '{4, 0,  32767, -32768, 1,  32767, -32768},
        '{4, 1,    100,   -100, 0,      0,      0},
        '{3, 1,      7,     -7, 0,      0,      0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;
    logic                cfg_we = 1'b0;
    logic [0:0]          cfg_index = '0;
    logic [POS_W-1:0]    cfg_data = '0;

    stereo_t             awaited_pairs [$];
    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    logic                hold_req = 1'b0;
    logic                hold_seen = 1'b0;
    int                  hold_left = 0;

    logic signed [SAMPLE_W-1:0] left_ring [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] right_ring [RING_DEPTH];
    ring_idx_t           model_idx;
    logic [POS_W-1:0]    model_pos;
    logic                model_en;

    stereo_position_delay_gain dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic stereo_t spatialize(input stereo_t x);
        stereo_t          y;
        logic [POS_W-1:0] p;
        int               lf;
        int               rf;
        int               ld;
        int               rd;
        int               s;
        if (!model_en)
        begin
            return x;
        end
        p = (model_pos == 0) ? POS_W'(1) : (model_pos > 5) ? POS_W'(5) : model_pos;
        ld = 0;
        rd = 0;
        case (p)
            1:
            begin
                lf = 5;
                rf = 0;
            end
            2:
            begin
                lf = 4;
                rf = 3;
                rd = DELAY_SAMPLES;
            end
            3:
            begin
                lf = 5;
                rf = 5;
            end
            4:
            begin
                lf = 3;
                rf = 4;
                ld = DELAY_SAMPLES;
            end
            default:
            begin
                lf = 0;
                rf = 5;
            end
        endcase
        left_ring[(int'(model_idx) + ld) % RING_DEPTH] = x.left;
        right_ring[(int'(model_idx) + rd) % RING_DEPTH] = x.right;
        s = left_ring[model_idx];
        y.left = SAMPLE_W'((s * lf) / 5);
        s = right_ring[model_idx];
        y.right = SAMPLE_W'((s * rf) / 5);
        model_idx = ring_idx_t'((int'(model_idx) + 1) % RING_DEPTH);
        return y;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_pair(input stereo_t d, input bit typed, input stereo_t typed_out);
        stereo_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = spatialize(d);
        awaited_pairs.push_back(typed ? typed_out : predicted);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (awaited_pairs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [POS_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POSITION)
            model_pos = val;
        else
            model_en = val[0];
    endtask

    task automatic set_config(input logic [POS_W-1:0] pos, input logic en);
        if (pos != model_pos || en != model_en)
        begin
            wait_drain();
            write_reg(REG_POSITION, pos);
            write_reg(REG_ENABLE, POS_W'(en));
        end
    endtask

    task automatic note_failure(input string what, input stereo_t want, input stereo_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR %s: expected L=%0d R=%0d, got L=%0d R=%0d",
                     what, want.left, want.right, got.left, got.right);
    endtask

    // receiver: random stalls plus a long hold-off whenever hold_req toggles
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // output checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_pairs.size() == 0)
                    note_failure("unexpected output transaction", '0, m_axis_tdata);
                else if (stereo_t'(m_axis_tdata) !== awaited_pairs[0])
                begin
                    if (m_axis_tdata[SAMPLE_W-1:0] !== awaited_pairs[0].left)
                        note_failure("left_out mismatch", awaited_pairs[0], m_axis_tdata);
                    if (m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W] !== awaited_pairs[0].right)
                        note_failure("right_out mismatch", awaited_pairs[0], m_axis_tdata);
                end
                if (awaited_pairs.size() != 0)
                    void'(awaited_pairs.pop_front());
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        stereo_t d;
        stereo_t t;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            left_ring[i]  = '0;
            right_ring[i] = '0;
        end
        model_idx = '0;
        model_pos = 3'd3;
        model_en  = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            set_config(POS_W'(DIRECTED[i].pos), DIRECTED[i].en[0]);
            d.left  = SAMPLE_W'(DIRECTED[i].l);
            d.right = SAMPLE_W'(DIRECTED[i].r);
            t.left  = SAMPLE_W'(DIRECTED[i].el);
            t.right = SAMPLE_W'(DIRECTED[i].er);
            send_pair(d, DIRECTED[i].chk != 0, t);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drain();
            if (ph > 0)
            begin
                write_reg(REG_POSITION, POS_W'($urandom_range(7)));
                write_reg(REG_ENABLE, POS_W'($urandom_range(4) != 0));
            end
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  = 85;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 85;
                end
                default:
                begin
                    send_idle_pct  = 16;
                    recv_stall_pct <= 16;
                end
            endcase
            // long output hold-off while the input keeps streaming
            if (ph == 0)
                hold_req <= ~hold_req;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                d.left  = rand_sample();
                d.right = rand_sample();
                send_pair(d, 1'b0, '0);
            end
        end

        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
src/spd_pkg.sv
src/spd_ram.sv
src/spd_lane.sv
src/stereo_position_delay_gain.sv
test/stereo_position_delay_gain_tb.sv
